// File: rtl/scm_pkg.sv
// Shared types and constants of the sound card mailbox mixer.
package scm_pkg;

  // Bus access kinds carried in the action field.
  typedef enum logic [2:0] {
    ACT_HOST_WR  = 3'd0,
    ACT_HOST_RD  = 3'd1,
    ACT_CARD_RD  = 3'd2,
    ACT_CARD_WR  = 3'd3,
    ACT_MEM_RD   = 3'd4
  } action_e;

  // Card-side port numbers (low four address bits).
  localparam logic [3:0] PORT_PAGE      = 4'd0;
  localparam logic [3:0] PORT_COMMAND   = 4'd1;
  localparam logic [3:0] PORT_DATA      = 4'd2;
  localparam logic [3:0] PORT_SET_DATA  = 4'd3;
  localparam logic [3:0] PORT_STATUS    = 4'd4;
  localparam logic [3:0] PORT_CLR_CMD   = 4'd5;
  localparam logic [3:0] PORT_VOL1      = 4'd6;
  localparam logic [3:0] PORT_VOL2      = 4'd7;
  localparam logic [3:0] PORT_VOL3      = 4'd8;
  localparam logic [3:0] PORT_VOL4      = 4'd9;
  localparam logic [3:0] PORT_PAGE_FLAG = 4'd10;
  localparam logic [3:0] PORT_VOL_FLAG  = 4'd11;

  // Configuration register indexes.
  localparam logic CFG_CARD_ENABLE = 1'b0;
  localparam logic CFG_STEREO_MODE = 1'b1;

  // Decode and reset constants.
  localparam logic [7:0]  HOST_DEC_MASK  = 8'hF7;
  localparam logic [7:0]  HOST_DEC_MATCH = 8'hB3;
  localparam logic [15:0] SAMPLE_MASK    = 16'hE300;
  localparam logic [15:0] SAMPLE_BASE    = 16'h6000;
  localparam logic [7:0]  STATUS_RESET   = 8'h7E;
  localparam logic [7:0]  SAMPLE_RESET   = 8'h80;
  localparam logic [7:0]  UNUSED_PORT    = 8'hFF;

  localparam int unsigned NUM_CH  = 4;
  localparam int unsigned VOL_W   = 6;
  localparam int unsigned SMP_W   = 8;
  localparam int unsigned MIX_W   = 14;
  localparam int unsigned CFG_W   = 1;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             accepted;
    logic             bank_is_rom;
    logic [5:0]       bank_page;
    logic [MIX_W-1:0] mix_left;
    logic [MIX_W-1:0] mix_right;
  } out_item_t;

endpackage

// File: rtl/scm_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface scm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/sound_card_mailbox_mixer.sv
// Top level of the sound card mailbox mixer: access decode, mailbox state and mix.
//
// Usage: every bus access of the host or of the card processor enters as one
// transfer on in_i (action, address, data). Host port writes/reads decode when
// (address & 0xF7) == 0xB3; card port accesses use the low four address bits;
// card memory reads in the sample window capture a channel sample.
// Each access yields exactly one result on out_o: read data, the accepted flag,
// the upper-bank mapping and the left/right mix after the access took effect.
// Configuration (card enable, stereo mode) is written through cfg_we_i,
// cfg_index_i and cfg_data_i while no access is in flight.
// The state update, the four 8x6 volume products and the adder tree sit
// between the input handshake and the result register.
// Throughput: one access per cycle; in_i.ready stays high while the result
// register is empty or its result is taken in the same cycle.
// Stall: when out_o.ready is low with a result held, the result holds and
// in_i.ready drops until the result transfers; no access is lost.
// Reset (rst_ni low, asynchronous): status flags 0x7E, mailbox bytes, page,
// volumes and bank mapping zero, samples 0x80, card disabled, stereo on,
// result register empty.
module sound_card_mailbox_mixer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  scm_stream_if.sink               in_i,
  scm_stream_if.source             out_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [scm_pkg::CFG_W-1:0] cfg_data_i
);
  import scm_pkg::*;

  // Configuration.
  logic card_enable_q, stereo_mode_q;

  // Card state.
  logic [7:0]       status_q, status_d;
  logic [7:0]       host_data_q, host_data_d;
  logic [7:0]       host_cmd_q, host_cmd_d;
  logic [7:0]       card_out_q, card_out_d;
  logic [7:0]       page_sel_q, page_sel_d;
  logic [VOL_W-1:0] vol_q [NUM_CH];
  logic [VOL_W-1:0] vol_d [NUM_CH];
  logic [SMP_W-1:0] smp_q [NUM_CH];
  logic [SMP_W-1:0] smp_d [NUM_CH];
  logic             bank_rom_q, bank_rom_d;
  logic [5:0]       bank_page_q, bank_page_d;

  // Result register.
  logic      out_valid_q;
  out_item_t out_q, res_d;

  logic      in_fire;
  in_item_t  it;
  logic [3:0] port;
  logic       host_hit;
  logic [4:0] sel;
  logic [15:0] smp_win;

  logic [MIX_W-1:0] prod [NUM_CH];
  logic [14:0]      sum_lo, sum_hi;
  logic [15:0]      sum_all;

  assign in_i.ready    = !out_valid_q || out_o.ready;
  assign in_fire       = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  assign it       = in_i.payload;
  assign port     = it.address[3:0];
  assign host_hit = card_enable_q && ((it.address[7:0] & HOST_DEC_MASK) == HOST_DEC_MATCH);
  assign sel      = it.data[4:0];
  assign smp_win  = it.address & SAMPLE_MASK;

  // Next state and read data for the access on the input.
  always_comb begin
    status_d    = status_q;
    host_data_d = host_data_q;
    host_cmd_d  = host_cmd_q;
    card_out_d  = card_out_q;
    page_sel_d  = page_sel_q;
    vol_d       = vol_q;
    smp_d       = smp_q;
    bank_rom_d  = bank_rom_q;
    bank_page_d = bank_page_q;
    res_d       = '0;

    unique case (it.action)
      ACT_HOST_WR: begin
        if (host_hit) begin
          res_d.accepted = 1'b1;
          if (it.address[3]) begin
            host_cmd_d  = it.data;
            status_d[0] = 1'b1;
          end else begin
            host_data_d = it.data;
            status_d[7] = 1'b1;
          end
        end
      end
      ACT_HOST_RD: begin
        if (host_hit) begin
          res_d.accepted = 1'b1;
          if (it.address[3]) begin
            res_d.read_data = status_q;
          end else begin
            res_d.read_data = card_out_q;
            status_d[7]     = 1'b0;
          end
        end
      end
      ACT_CARD_RD: begin
        res_d.read_data = UNUSED_PORT;
        unique case (port)
          PORT_COMMAND: res_d.read_data = host_cmd_q;
          PORT_DATA: begin
            status_d[7]     = 1'b0;
            res_d.read_data = host_data_q;
          end
          PORT_SET_DATA:  status_d[7] = 1'b1;
          PORT_STATUS:    res_d.read_data = status_q;
          PORT_CLR_CMD:   status_d[0] = 1'b0;
          PORT_PAGE_FLAG: status_d[7] = !page_sel_q[0];
          PORT_VOL_FLAG:  status_d[0] = vol_q[0][5];
          default: ;
        endcase
      end
      ACT_CARD_WR: begin
        unique case (port)
          PORT_PAGE: begin
            page_sel_d = it.data;
            if (sel == 5'd0) begin
              bank_rom_d  = 1'b1;
              bank_page_d = '0;
            end else begin
              bank_rom_d  = 1'b0;
              bank_page_d = {sel - 5'd1, 1'b0};
            end
          end
          PORT_DATA: status_d[7] = 1'b0;
          PORT_SET_DATA: begin
            status_d[7] = 1'b1;
            card_out_d  = it.data;
          end
          PORT_CLR_CMD:   status_d[0] = 1'b0;
          PORT_VOL1:      vol_d[0] = it.data[VOL_W-1:0];
          PORT_VOL2:      vol_d[1] = it.data[VOL_W-1:0];
          PORT_VOL3:      vol_d[2] = it.data[VOL_W-1:0];
          PORT_VOL4:      vol_d[3] = it.data[VOL_W-1:0];
          PORT_PAGE_FLAG: status_d[7] = !page_sel_q[0];
          PORT_VOL_FLAG:  status_d[0] = vol_q[0][5];
          default: ;
        endcase
      end
      ACT_MEM_RD: begin
        res_d.read_data = it.data;
        // Sample window: bits 9:8 pick the channel.
        if ((smp_win & ~16'h0300) == SAMPLE_BASE) begin
          smp_d[smp_win[9:8]] = it.data;
        end
      end
      default: ;
    endcase

    res_d.bank_is_rom = bank_rom_d;
    res_d.bank_page   = bank_page_d;

    // Mix from the updated samples and volumes.
    for (int i = 0; i < NUM_CH; i++) begin
      prod[i] = MIX_W'(smp_d[i]) * MIX_W'(vol_d[i]);
    end
    sum_lo  = 15'(prod[0]) + 15'(prod[1]);
    sum_hi  = 15'(prod[2]) + 15'(prod[3]);
    sum_all = 16'(sum_lo) + 16'(sum_hi);
    if (card_enable_q) begin
      if (stereo_mode_q) begin
        res_d.mix_left  = sum_lo[14:1];
        res_d.mix_right = sum_hi[14:1];
      end else begin
        res_d.mix_left  = sum_all[15:2];
        res_d.mix_right = sum_all[15:2];
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_enable_q <= 1'b0;
      stereo_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CARD_ENABLE: card_enable_q <= cfg_data_i[0];
        CFG_STEREO_MODE: stereo_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Card state: advance on every accepted access.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= STATUS_RESET;
      host_data_q <= '0;
      host_cmd_q  <= '0;
      card_out_q  <= '0;
      page_sel_q  <= '0;
      bank_rom_q  <= 1'b0;
      bank_page_q <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        vol_q[i] <= '0;
        smp_q[i] <= SAMPLE_RESET;
      end
    end else if (in_fire) begin
      status_q    <= status_d;
      host_data_q <= host_data_d;
      host_cmd_q  <= host_cmd_d;
      card_out_q  <= card_out_d;
      page_sel_q  <= page_sel_d;
      bank_rom_q  <= bank_rom_d;
      bank_page_q <= bank_page_d;
      vol_q       <= vol_d;
      smp_q       <= smp_d;
    end
  end

  // Result register: load on accept, drop once transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res_d;
    end
  end

endmodule

// File: dv/sound_card_mailbox_mixer_checker.sv
`timescale 1ns / 100ps
// Scoreboard of the sound card mailbox mixer: predicts every access result and compares it.
module sound_card_mailbox_mixer_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  scm_stream_if                     access_i,
  scm_stream_if                     result_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [scm_pkg::CFG_W-1:0] cfg_data_i,
  output int unsigned               mismatches_o,
  output int unsigned               outstanding_o
);
  import scm_pkg::*;

  localparam int unsigned     DATA_FLAG = 7;
  localparam int unsigned     CMD_FLAG  = 0;
  localparam logic [15:0]     SAMPLE_CH = 16'h0300;

  // Shadow copy of the card state and configuration.
  logic             card_on;
  logic             stereo;
  logic [7:0]       status;
  logic [7:0]       host_data;
  logic [7:0]       host_cmd;
  logic [7:0]       card_out;
  logic [7:0]       page_reg;
  logic [VOL_W-1:0] volume [NUM_CH];
  logic [SMP_W-1:0] sample [NUM_CH];
  logic             bank_rom;
  logic [5:0]       bank_pg;

  out_item_t expected_results [$];
  in_item_t  access;
  out_item_t want;
  out_item_t got;

  task automatic clear_card();
    card_on   = 1'b0;
    stereo    = 1'b1;
    status    = STATUS_RESET;
    host_data = '0;
    host_cmd  = '0;
    card_out  = '0;
    page_reg  = '0;
    bank_rom  = 1'b0;
    bank_pg   = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      volume[i] = '0;
      sample[i] = SAMPLE_RESET;
    end
  endtask

  // Flag ports shared by card reads and writes.
  task automatic flag_port(input logic [3:0] port);
    if (port == PORT_PAGE_FLAG) status[DATA_FLAG] = ~page_reg[0];
    else if (port == PORT_VOL_FLAG) status[CMD_FLAG] = volume[0][5];
  endtask

  task automatic mailbox_access(input in_item_t a, output out_item_t r);
    logic [3:0]  port;
    logic [4:0]  sel;
    int unsigned prod [NUM_CH];
    int unsigned left;
    int unsigned right;
    r    = '0;
    port = a.address[3:0];
    case (a.action)
      ACT_HOST_WR, ACT_HOST_RD: begin
        if (card_on && (a.address[7:0] & HOST_DEC_MASK) == HOST_DEC_MATCH) begin
          r.accepted = 1'b1;
          if (a.action == ACT_HOST_WR) begin
            if (a.address[3]) begin
              host_cmd         = a.data;
              status[CMD_FLAG] = 1'b1;
            end else begin
              host_data         = a.data;
              status[DATA_FLAG] = 1'b1;
            end
          end else if (a.address[3]) begin
            r.read_data = status;
          end else begin
            r.read_data       = card_out;
            status[DATA_FLAG] = 1'b0;
          end
        end
      end
      ACT_CARD_RD: begin
        r.read_data = UNUSED_PORT;
        case (port)
          PORT_COMMAND:  r.read_data = host_cmd;
          PORT_DATA: begin
            status[DATA_FLAG] = 1'b0;
            r.read_data       = host_data;
          end
          PORT_SET_DATA: status[DATA_FLAG] = 1'b1;
          PORT_STATUS:   r.read_data = status;
          PORT_CLR_CMD:  status[CMD_FLAG] = 1'b0;
          default:       flag_port(port);
        endcase
      end
      ACT_CARD_WR: begin
        case (port)
          PORT_PAGE: begin
            page_reg = a.data;
            sel      = a.data[4:0];
            bank_rom = (sel == 5'd0);
            bank_pg  = (sel == 5'd0) ? 6'd0 : {sel - 5'd1, 1'b0};
          end
          PORT_DATA:     status[DATA_FLAG] = 1'b0;
          PORT_SET_DATA: begin
            status[DATA_FLAG] = 1'b1;
            card_out          = a.data;
          end
          PORT_CLR_CMD:  status[CMD_FLAG] = 1'b0;
          PORT_VOL1, PORT_VOL2, PORT_VOL3, PORT_VOL4:
            volume[2'(port - PORT_VOL1)] = a.data[VOL_W-1:0];
          default:       flag_port(port);
        endcase
      end
      ACT_MEM_RD: begin
        r.read_data = a.data;
        if ((a.address & SAMPLE_MASK & ~SAMPLE_CH) == SAMPLE_BASE)
          sample[a.address[9:8]] = a.data;
      end
      default: ;
    endcase

    left  = 0;
    right = 0;
    if (card_on) begin
      for (int i = 0; i < NUM_CH; i++) prod[i] = 32'(sample[i]) * 32'(volume[i]);
      if (stereo) begin
        left  = (prod[0] + prod[1]) >> 1;
        right = (prod[2] + prod[3]) >> 1;
      end else begin
        left  = (prod[0] + prod[1] + prod[2] + prod[3]) >> 2;
        right = left;
      end
    end
    r.bank_is_rom = bank_rom;
    r.bank_page   = bank_pg;
    r.mix_left    = left[MIX_W-1:0];
    r.mix_right   = right[MIX_W-1:0];
  endtask

  task automatic check_field(input string field, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_card();
      expected_results.delete();
      mismatches_o = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        got = result_i.payload;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data",   want.read_data,   got.read_data);
          check_field("accepted",    want.accepted,    got.accepted);
          check_field("bank_is_rom", want.bank_is_rom, got.bank_is_rom);
          check_field("bank_page",   want.bank_page,   got.bank_page);
          check_field("mix_left",    want.mix_left,    got.mix_left);
          check_field("mix_right",   want.mix_right,   got.mix_right);
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_CARD_ENABLE) card_on = cfg_data_i[0];
        else if (cfg_index_i == CFG_STEREO_MODE) stereo = cfg_data_i[0];
      end
      if (access_i.valid && access_i.ready) begin
        access = access_i.payload;
        mailbox_access(access, want);
        expected_results.push_back(want);
      end
    end
    outstanding_o <= expected_results.size();
  end

endmodule

// File: dv/sound_card_mailbox_mixer_tb.sv
`timescale 1ns / 100ps
// Testbench top of the sound card mailbox mixer: stimulus, handshake pacing and verdict.
module sound_card_mailbox_mixer_tb;
  import scm_pkg::*;

  // Leave a wide margin over the slowest legal run.
  localparam int unsigned CYCLE_LIMIT     = 400_000;
  localparam int unsigned RANDOM_PHASES   = 7;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned MAX_PAUSE       = 16;

  // Codes the package leaves out: undefined actions and unused card ports.
  localparam logic [2:0]  ACT_UNDEF_LO   = 3'd5;
  localparam logic [2:0]  ACT_UNDEF_HI   = 3'd7;
  localparam logic [3:0]  PORT_UNUSED_LO = 4'd12;
  localparam logic [3:0]  PORT_UNUSED_HI = 4'd15;
  localparam logic [7:0]  HOST_SEL_CMD   = 8'h08;
  localparam logic [15:0] SAMPLE_CH      = 16'h0300;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int unsigned      mismatches;
  int unsigned      outstanding;
  int unsigned      cycles = 0;
  // When set, neither side inserts pauses: back-to-back transfers.
  logic             calm = 1'b0;

  scm_stream_if #(.T(in_item_t))  access_if ();
  scm_stream_if #(.T(out_item_t)) result_if ();

  sound_card_mailbox_mixer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (access_if),
    .out_o       (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  sound_card_mailbox_mixer_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .access_i      (access_if),
    .result_i      (result_if),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Pause length for one transfer: often none, otherwise random up to MAX_PAUSE.
  function automatic int unsigned pick_pause();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(1, MAX_PAUSE);
  endfunction

  // Drive one access and hold it until it transfers. Valid stays high
  // when the next access follows without a pause.
  task automatic send_access(input logic [2:0] act, input logic [15:0] addr,
                             input logic [7:0] wdata);
    int unsigned gap;
    gap = pick_pause();
    if (gap != 0) begin
      access_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    access_if.valid   <= 1'b1;
    access_if.payload <= '{action: act, address: addr, data: wdata};
    do @(posedge clk_i); while (!access_if.ready);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic settle();
    access_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_config(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random access weighted toward traffic that moves state: decoding host
  // mailbox accesses, card port accesses and sample window reads. The rest
  // is noise: stray host addresses, other memory and undefined actions.
  function automatic in_item_t random_access();
    in_item_t    it;
    int unsigned pick;
    it.action  = ACT_MEM_RD;
    it.address = 16'($urandom);
    it.data    = 8'($urandom);
    pick       = $urandom_range(0, 99);
    if (pick < 30) begin
      // keep address bit 3 random: data or command register
      it.action       = $urandom_range(0, 1) ? ACT_HOST_RD : ACT_HOST_WR;
      it.address[7:0] = HOST_DEC_MATCH | (it.address[7:0] & ~HOST_DEC_MASK);
    end else if (pick < 35) begin
      it.action = $urandom_range(0, 1) ? ACT_HOST_RD : ACT_HOST_WR;
    end else if (pick < 70) begin
      it.action = $urandom_range(0, 1) ? ACT_CARD_RD : ACT_CARD_WR;
    end else if (pick < 90) begin
      it.address = (it.address & ~(SAMPLE_MASK & ~SAMPLE_CH)) | SAMPLE_BASE;
    end else if (pick >= 95) begin
      it.action = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
    end
    return it;
  endfunction

  // Result side: stall a random number of cycles before each transfer.
  initial begin
    int unsigned stall;
    result_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_pause();
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
    end
  end

  initial begin
    in_item_t   item;
    logic [1:0] setting;
    rst_ni            <= 1'b0;
    access_if.valid   <= 1'b0;
    access_if.payload <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_CARD_ENABLE;
    cfg_data          <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Card still disabled after reset: host accesses refused, card side live.
    send_access(ACT_HOST_WR, {8'h00, HOST_DEC_MATCH}, 8'hFF);
    send_access(ACT_HOST_RD, {8'hFF, HOST_DEC_MATCH | HOST_SEL_CMD}, 8'h00);
    send_access(ACT_CARD_WR, {12'hFFF, PORT_VOL1}, 8'hFF);
    send_access(ACT_MEM_RD, SAMPLE_BASE, 8'hFF);
    settle();

    // Enable the card in mono mode and walk every action and every port but VOL1.
    write_config(CFG_CARD_ENABLE, 1'b1);
    write_config(CFG_STEREO_MODE, 1'b0);
    send_access(ACT_HOST_WR, {8'h00, HOST_DEC_MATCH}, 8'hFF);
    send_access(ACT_HOST_WR, {8'hFF, HOST_DEC_MATCH | HOST_SEL_CMD}, 8'h00);
    send_access(ACT_HOST_RD, {8'h12, HOST_DEC_MATCH | HOST_SEL_CMD}, 8'h00);
    send_access(ACT_CARD_RD, {12'hFFF, PORT_COMMAND}, 8'h00);
    send_access(ACT_CARD_RD, {12'h000, PORT_DATA}, 8'hFF);
    send_access(ACT_CARD_RD, {12'h5A5, PORT_SET_DATA}, 8'h00);
    send_access(ACT_CARD_RD, {12'h000, PORT_STATUS}, 8'h00);
    send_access(ACT_CARD_RD, {12'hFFF, PORT_CLR_CMD}, 8'h00);
    // ROM mapping, then the highest RAM page
    send_access(ACT_CARD_WR, {12'h000, PORT_PAGE}, 8'h00);
    send_access(ACT_CARD_WR, {12'hFFF, PORT_PAGE}, 8'hFF);
    send_access(ACT_CARD_WR, {12'h000, PORT_SET_DATA}, 8'hA5);
    send_access(ACT_HOST_RD, {8'hFF, HOST_DEC_MATCH}, 8'h00);
    send_access(ACT_CARD_WR, {12'h000, PORT_DATA}, 8'h00);
    send_access(ACT_CARD_WR, {12'h000, PORT_CLR_CMD}, 8'h00);
    send_access(ACT_CARD_WR, {12'h000, PORT_VOL2}, 8'h3F);
    send_access(ACT_CARD_WR, {12'h000, PORT_VOL3}, 8'h20);
    send_access(ACT_CARD_WR, {12'h000, PORT_VOL4}, 8'hFF);
    // Top edge of the sample window and an address outside it
    send_access(ACT_MEM_RD, SAMPLE_BASE | SAMPLE_CH | 16'h00FF, 8'hFF);
    send_access(ACT_MEM_RD, 16'hFFFF, 8'h00);
    send_access(ACT_CARD_RD, {12'h000, PORT_PAGE_FLAG}, 8'h00);
    send_access(ACT_CARD_WR, {12'h000, PORT_VOL_FLAG}, 8'h00);
    send_access(ACT_CARD_RD, {12'hFFF, PORT_UNUSED_HI}, 8'h00);
    send_access(ACT_CARD_WR, {12'h000, PORT_UNUSED_LO}, 8'hFF);
    send_access(ACT_UNDEF_LO, 16'hFFFF, 8'hFF);
    send_access(ACT_UNDEF_HI, {8'h00, HOST_DEC_MATCH}, 8'hFF);
    settle();

    // Random phases. Each phase drains fully before the settings change.
    // Phase 2 turns the card off; phases 4 and 5 draw their setting.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0, 3:    setting = 2'b11;
        1, 6:    setting = 2'b01;
        2:       setting = 2'b00;
        default: setting = 2'($urandom);
      endcase
      write_config(CFG_CARD_ENABLE, setting[0]);
      write_config(CFG_STEREO_MODE, setting[1]);
      calm = (p % 3 == 1);
      repeat (ITEMS_PER_PHASE) begin
        item = random_access();
        send_access(item.action, item.address, item.data);
      end
      settle();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
